@@ hdl/topological_sort_kahn_top_assert.svh @@
// Assertion macros shared by the topological sort checker.
`ifndef TOPOLOGICAL_SORT_KAHN_TOP_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tsk_pkg.sv @@
// Shared constants for the topological sort block.
`timescale 1ns / 1ps
`default_nettype none
package tsk_pkg;

    localparam int unsigned NODE_W        = 5;
    localparam int unsigned CNT_W         = 6;
    localparam int unsigned OUT_CAP       = 32;
    localparam int unsigned DEF_MAX_NODES = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

endpackage
`default_nettype wire

@@ hdl/topological_sort_kahn_top.sv @@
// Top level of the Kahn topological sort engine.
// Edge load: one transaction per cycle while idle, no result; the row is written in the cycle after acceptance.
// Run: in-degree pass, then per placed node a queue pop, queue read, row read and push of
// each node made ready, then a close and the emitted results; the single read ports set the pace.
// Reset: async, clears control, row valid flags and node_count (32); no clearing sweep.
`timescale 1ns / 1ps
`default_nettype none
module topological_sort_kahn_top #(
    parameter int unsigned MAX_NODES = tsk_pkg::DEF_MAX_NODES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsk_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tsk_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tsk_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [tsk_pkg::NODE_W-1:0]      source_node,
    input  logic [tsk_pkg::NODE_W-1:0]      target_node,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tsk_pkg::NODE_W-1:0]      node_index,
    output logic [tsk_pkg::CNT_W-1:0]       ordered_count,
    output logic                            cycle_error,
    output logic                            last
);
    import tsk_pkg::*;

    localparam int unsigned IW   = $clog2(MAX_NODES);
    localparam int unsigned NCAP = (MAX_NODES < OUT_CAP) ? MAX_NODES : OUT_CAP;
    localparam int unsigned DW   = $clog2(NCAP + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEG  = 4'd1;
    localparam logic [3:0] S_PUSH = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_QRD  = 4'd4;
    localparam logic [3:0] S_ROW  = 4'd5;
    localparam logic [3:0] S_DONE = 4'd6;
    localparam logic [3:0] S_EMRD = 4'd7;
    localparam logic [3:0] S_EMLD = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     node_count_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     tail_reg, tail_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IW-1:0]        rd_row_reg, rd_row_next;
    logic [MAX_NODES-1:0] zmask_reg, zmask_next;
    logic [MAX_NODES-1:0] row_vld_reg, row_vld_next;
    logic [DW-1:0]        deg_reg [MAX_NODES];
    logic [DW-1:0]        deg_next [MAX_NODES];

    logic                 upd_vld_reg;
    logic [IW-1:0]        upd_row_reg;
    logic [NODE_W-1:0]    upd_col_reg;
    logic                 fwd_reg;
    logic [MAX_NODES-1:0] last_wdata_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]    out_node_reg, out_node_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                 out_err_reg, out_err_next;
    logic                 out_last_reg, out_last_next;

    logic [CNT_W-1:0]     n_eff;
    logic [MAX_NODES-1:0] live;
    logic                 in_fire, edge_fire, run_fire, edge_ok, out_fire;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 adj_we;
    logic [IW-1:0]        adj_waddr, adj_raddr;
    logic [MAX_NODES-1:0] adj_wdata, adj_rdata, adj_base, row_bits;

    logic                 q_we;
    logic [IW-1:0]        q_waddr, q_raddr;
    logic [NODE_W-1:0]    q_wdata, q_rdata;

    logic [MAX_NODES-1:0] zlow;
    logic [NODE_W-1:0]    low_idx;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_NODE_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, node_count_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_wr && (reg_idx == REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (node_count_reg > CNT_W'(NCAP))
        begin
            n_eff = CNT_W'(NCAP);
        end
        else
        begin
            n_eff = node_count_reg;
        end
        for (int t = 0; t < MAX_NODES; t++)
        begin
            live[t] = (CNT_W'(t) < n_eff);
        end
    end

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign edge_fire = in_fire && (req_type == REQ_EDGE);
    assign run_fire  = in_fire && (req_type == REQ_RUN);
    assign edge_ok   = (CNT_W'(source_node) < n_eff) && (CNT_W'(target_node) < n_eff);
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid     = out_valid_reg;
    assign node_index    = out_node_reg;
    assign ordered_count = out_cnt_reg;
    assign cycle_error   = out_err_reg;
    assign last          = out_last_reg;

    // adjacency memory: read-modify-write of a row on edge load
    assign adj_we    = upd_vld_reg;
    assign adj_waddr = upd_row_reg;
    assign adj_base  = row_vld_reg[upd_row_reg] ? (fwd_reg ? last_wdata_reg : adj_rdata) : '0;
    assign adj_wdata = adj_base | ({{(MAX_NODES-1){1'b0}}, 1'b1} << upd_col_reg);
    assign row_bits  = adj_rdata & live & {MAX_NODES{row_vld_reg[rd_row_reg]}};

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  adj_raddr = IW'(source_node);
            S_DEG:   adj_raddr = cnt_reg[IW-1:0];
            S_QRD:   adj_raddr = IW'(q_rdata);
            default: adj_raddr = '0;
        endcase
    end

    tsk_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // ready queue; its first entries are also the placed order
    assign zlow    = zmask_reg & (~zmask_reg + {{(MAX_NODES-1){1'b0}}, 1'b1});
    assign q_we    = (state_reg == S_PUSH) && (zmask_reg != '0);
    assign q_waddr = tail_reg[IW-1:0];
    assign q_wdata = low_idx;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (zlow[i])
            begin
                low_idx = low_idx | NODE_W'(i);
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_POP:   q_raddr = head_reg[IW-1:0];
            default: q_raddr = cnt_reg[IW-1:0];
        endcase
    end

    tsk_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rd_pend_next   = rd_pend_reg;
        rd_row_next    = rd_row_reg;
        zmask_next     = zmask_reg;
        row_vld_next   = row_vld_reg;
        deg_next       = deg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_node_next  = out_node_reg;
        out_cnt_next   = out_cnt_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        if (upd_vld_reg)
        begin
            row_vld_next[upd_row_reg] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (run_fire)
                begin
                    state_next   = S_DEG;
                    cnt_next     = '0;
                    head_next    = '0;
                    tail_next    = '0;
                    rd_pend_next = 1'b0;
                    for (int t = 0; t < MAX_NODES; t++)
                    begin
                        deg_next[t] = '0;
                    end
                end
            end
            S_DEG:
            begin
                if (rd_pend_reg)
                begin
                    for (int t = 0; t < MAX_NODES; t++)
                    begin
                        deg_next[t] = deg_reg[t] + DW'(row_bits[t]);
                    end
                end
                if (cnt_reg < n_eff)
                begin
                    rd_pend_next = 1'b1;
                    rd_row_next  = cnt_reg[IW-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        state_next = S_PUSH;
                        for (int t = 0; t < MAX_NODES; t++)
                        begin
                            zmask_next[t] = live[t] && (deg_reg[t] == '0);
                        end
                    end
                end
            end
            S_PUSH:
            begin
                if (zmask_reg != '0)
                begin
                    tail_next  = tail_reg + CNT_W'(1);
                    zmask_next = zmask_reg & ~zlow;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                rd_row_next = IW'(q_rdata);
                state_next  = S_ROW;
            end
            S_ROW:
            begin
                for (int t = 0; t < MAX_NODES; t++)
                begin
                    zmask_next[t] = 1'b0;
                    if (row_bits[t] && (deg_reg[t] != '0))
                    begin
                        deg_next[t]   = deg_reg[t] - DW'(1);
                        zmask_next[t] = (deg_reg[t] == DW'(1));
                    end
                end
                state_next = S_PUSH;
            end
            S_DONE:
            begin
                row_vld_next = '0;
                if (!out_valid_reg || out_ready)
                begin
                    if (head_reg == n_eff)
                    begin
                        cnt_next   = '0;
                        state_next = S_EMRD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_node_next  = '0;
                        out_cnt_next   = head_reg;
                        out_err_next   = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_EMRD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_EMLD;
                end
            end
            S_EMLD:
            begin
                out_valid_next = 1'b1;
                out_node_next  = q_rdata;
                out_cnt_next   = head_reg;
                out_err_next   = 1'b0;
                out_last_next  = ((cnt_reg + CNT_W'(1)) == n_eff);
                cnt_next       = cnt_reg + CNT_W'(1);
                state_next     = ((cnt_reg + CNT_W'(1)) == n_eff) ? S_IDLE : S_EMRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            zmask_reg     <= '0;
            row_vld_reg   <= '0;
            upd_vld_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rd_pend_reg   <= rd_pend_next;
            zmask_reg     <= zmask_next;
            row_vld_reg   <= row_vld_next;
            upd_vld_reg   <= edge_fire && edge_ok;
            fwd_reg       <= upd_vld_reg && (upd_row_reg == IW'(source_node));
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg  <= rd_row_next;
        deg_reg     <= deg_next;
        upd_row_reg <= IW'(source_node);
        upd_col_reg <= target_node;
        if (upd_vld_reg)
        begin
            last_wdata_reg <= adj_wdata;
        end
        out_node_reg <= out_node_next;
        out_cnt_reg  <= out_cnt_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

endmodule
`default_nettype wire

@@ hdl/tsk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tsk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/tsk_checker.sv @@
// Port-level checks for the topological sort block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "topological_sort_kahn_top_assert.svh"
module tsk_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tsk_pkg::NODE_W-1:0] node_index,
    input logic [tsk_pkg::CNT_W-1:0]  ordered_count,
    input logic                       cycle_error,
    input logic                       last
);

    `TSK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(node_index) && $stable(ordered_count) && $stable(cycle_error) && $stable(last), "stalled result transaction changed")
    `TSK_ASSERT_SAME(a_err_form, out_valid && cycle_error, last && (node_index == '0), "cycle error result not last or nonzero node")
    `TSK_ASSERT_SAME(a_node_range, out_valid && !cycle_error, node_index < ordered_count, "ordered node outside node count")
    `TSK_ASSERT_SAME(a_emit_busy, out_valid && !cycle_error && !last, !in_ready, "input taken while order still emitting")

endmodule

bind topological_sort_kahn_top tsk_checker u_tsk_checker (.*);
`default_nettype wire

@@ bench/kahn_order_checker.sv @@
// Checker that mirrors the Kahn sort engine and compares every emitted order transaction.
`timescale 1ns / 1ps
module kahn_order_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tsk_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tsk_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            req_type,
    input  logic [tsk_pkg::NODE_W-1:0]      source_node,
    input  logic [tsk_pkg::NODE_W-1:0]      target_node,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [tsk_pkg::NODE_W-1:0]      node_index,
    input  logic [tsk_pkg::CNT_W-1:0]       ordered_count,
    input  logic                            cycle_error,
    input  logic                            last,
    output int                              mismatches,
    output int                              pending_results
);
    import tsk_pkg::*;

    localparam int ROWS = DEF_MAX_NODES;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CNT_W-1:0]  placed;
        logic              cycle_err;
        logic              run_end;
    } order_entry_t;

    order_entry_t      order_due[$];
    logic [ROWS-1:0]   adjacency [ROWS];
    logic [CNT_W-1:0]  node_count_reg;

    function automatic int live_nodes(input logic [CNT_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n < 1) n = 1;
        if (n > ROWS) n = ROWS;
        if (n > OUT_CAP) n = OUT_CAP;
        return n;
    endfunction

    // In-degree pass, FIFO seeded in index order, successors visited in index order.
    task automatic sort_graph();
        int n;
        int head;
        int tail;
        int placed;
        int v;
        int deg [ROWS];
        int fifo [ROWS];
        int order [ROWS];
        order_entry_t entry;
        n = live_nodes(node_count_reg);
        head = 0;
        tail = 0;
        placed = 0;
        for (int t = 0; t < n; t++)
        begin
            deg[t] = 0;
            for (int s = 0; s < n; s++)
                if (adjacency[s][t]) deg[t]++;
        end
        for (int t = 0; t < n; t++)
        begin
            if (deg[t] == 0)
            begin
                fifo[tail] = t;
                tail++;
            end
        end
        while (head < tail && head < n)
        begin
            v = fifo[head];
            head++;
            order[placed] = v;
            placed++;
            for (int t = 0; t < n; t++)
            begin
                if (adjacency[v][t] && deg[t] > 0)
                begin
                    deg[t]--;
                    if (deg[t] == 0 && tail < n)
                    begin
                        fifo[tail] = t;
                        tail++;
                    end
                end
            end
        end
        for (int s = 0; s < ROWS; s++)
            adjacency[s] = '0;
        if (placed == n)
        begin
            for (int k = 0; k < n; k++)
            begin
                entry.node      = NODE_W'(order[k]);
                entry.placed    = CNT_W'(placed);
                entry.cycle_err = 1'b0;
                entry.run_end   = (k == n - 1);
                order_due       = {order_due, entry};
            end
        end
        else
        begin
            entry.node      = '0;
            entry.placed    = CNT_W'(placed);
            entry.cycle_err = 1'b1;
            entry.run_end   = 1'b1;
            order_due       = {order_due, entry};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        order_entry_t want;
        int n;
        if (!rst_n)
        begin
            node_count_reg = NODE_COUNT_RST;
            for (int s = 0; s < ROWS; s++)
                adjacency[s] = '0;
            order_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_NODE_COUNT)
                node_count_reg = pwdata[CNT_W-1:0];

            if (in_valid && in_ready)
            begin
                n = live_nodes(node_count_reg);
                if (req_type == REQ_EDGE)
                begin
                    if (source_node < n && target_node < n)
                        adjacency[source_node][target_node] = 1'b1;
                end
                else
                    sort_graph();
            end

            if (out_valid && out_ready)
            begin
                if (order_due.size() == 0)
                begin
                    $error("unexpected result transaction: node_index %0d", node_index);
                    mismatches++;
                end
                else
                begin
                    want = order_due.pop_front();
                    if (node_index !== want.node)
                    begin
                        $error("node_index: expected %0d, got %0d", want.node, node_index);
                        mismatches++;
                    end
                    if (ordered_count !== want.placed)
                    begin
                        $error("ordered_count: expected %0d, got %0d",
                               want.placed, ordered_count);
                        mismatches++;
                    end
                    if (cycle_error !== want.cycle_err)
                    begin
                        $error("cycle_error: expected %0d, got %0d",
                               want.cycle_err, cycle_error);
                        mismatches++;
                    end
                    if (last !== want.run_end)
                    begin
                        $error("last: expected %0d, got %0d", want.run_end, last);
                        mismatches++;
                    end
                end
            end
        end
        pending_results = order_due.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the Kahn sort bench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import tsk_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = APB_ADDR_W'({REG_NODE_COUNT, 2'b00});

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_ready;
    logic                   req_type;
    logic [NODE_W-1:0]      source_node;
    logic [NODE_W-1:0]      target_node;
    logic                   out_valid;
    logic                   out_ready;
    logic [NODE_W-1:0]      node_index;
    logic [CNT_W-1:0]       ordered_count;
    logic                   cycle_error;
    logic                   last;

    int   mismatches;
    int   pending_results;
    logic hold_request = 1'b0;
    int   burst_left;
    int   cycle_count;
    int   cur_cfg;
    int   nodes;
    int   random_items;
    int   pick;
    int   edge_total;
    int   kind;
    int   a;
    int   b;
    int   j;
    int   tmp;
    bit   loops_ok;
    int   rank [32];

    topological_sort_kahn_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .source_node   (source_node),
        .target_node   (target_node),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .node_index    (node_index),
        .ordered_count (ordered_count),
        .cycle_error   (cycle_error),
        .last          (last)
    );

    kahn_order_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .source_node     (source_node),
        .target_node     (target_node),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .node_index      (node_index),
        .ordered_count   (ordered_count),
        .cycle_error     (cycle_error),
        .last            (last),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Called at a falling edge; returns at a falling edge after the handshake.
    task automatic offer(input logic rt, input int s, input int t);
        in_valid    <= 1'b1;
        req_type    <= rt;
        source_node <= NODE_W'(s);
        target_node <= NODE_W'(t);
        do @(posedge clk); while (in_ready !== 1'b1);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_node_count(input int value);
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_cfg = value;
    endtask

    initial
    begin : receiver
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        req_type    = REQ_EDGE;
        source_node = '0;
        target_node = '0;
        burst_left  = 0;
        cur_cfg     = int'(NODE_COUNT_RST);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty graph at the reset size: all nodes ready at once
        offer(REQ_RUN, 31, 31);
        // extremes of the index range, duplicate merge
        offer(REQ_EDGE, 31, 0);
        offer(REQ_EDGE, 31, 0);
        offer(REQ_EDGE, 0, 1);
        offer(REQ_EDGE, 2, 31);
        offer(REQ_RUN, 0, 0);
        // self edge
        offer(REQ_EDGE, 5, 5);
        offer(REQ_RUN, 0, 0);
        // two-node loop
        offer(REQ_EDGE, 0, 1);
        offer(REQ_EDGE, 1, 0);
        offer(REQ_RUN, 21, 10);
        // single node: out-of-range edge dropped, then self edge
        set_node_count(1);
        offer(REQ_EDGE, 1, 0);
        offer(REQ_RUN, 0, 0);
        offer(REQ_EDGE, 0, 0);
        offer(REQ_RUN, 0, 0);
        // count below and above the legal range
        set_node_count(0);
        offer(REQ_RUN, 0, 0);
        set_node_count(63);
        offer(REQ_EDGE, 21, 10);
        offer(REQ_EDGE, 10, 21);
        offer(REQ_RUN, 0, 0);
        // count lowered after loading
        set_node_count(32);
        offer(REQ_EDGE, 20, 3);
        offer(REQ_EDGE, 3, 2);
        offer(REQ_EDGE, 1, 20);
        set_node_count(4);
        offer(REQ_RUN, 0, 0);
        set_node_count(2);
        offer(REQ_EDGE, 1, 0);
        offer(REQ_RUN, 0, 0);

        // back pressure: receiver holds off while runs and edges keep coming
        set_node_count(32);
        hold_request = 1'b1;
        offer(REQ_RUN, 0, 0);
        for (int i = 0; i < 8; i++)
            offer(REQ_EDGE, i, i + 1);
        offer(REQ_RUN, 0, 0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    set_node_count(0);
                else if (pick == 1)
                    set_node_count($urandom_range(33, 63));
                else if (pick <= 4)
                    set_node_count($urandom_range(9, 32));
                else
                    set_node_count($urandom_range(1, 8));
            end
            nodes = (cur_cfg < 1) ? 1 : (cur_cfg > 32) ? 32 : cur_cfg;
            for (int i = 0; i < nodes; i++)
                rank[i] = i;
            for (int i = nodes - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = rank[i];
                rank[i] = rank[j];
                rank[j] = tmp;
            end
            loops_ok = ($urandom_range(0, 3) == 0);
            edge_total = $urandom_range(0, 2 * nodes);
            for (int e = 0; e < edge_total; e++)
            begin
                kind = $urandom_range(0, 15);
                a = $urandom_range(0, nodes - 1);
                b = $urandom_range(0, nodes - 1);
                if (kind == 0)
                    offer(REQ_EDGE, $urandom_range(0, 31), $urandom_range(0, 31));
                else if (loops_ok && kind == 1)
                    offer(REQ_EDGE, rank[(a > b) ? a : b], rank[(a < b) ? a : b]);
                else if (a != b)
                    offer(REQ_EDGE, rank[(a < b) ? a : b], rank[(a > b) ? a : b]);
                random_items++;
            end
            if (nodes > 2 && $urandom_range(0, 7) == 0)
                set_node_count($urandom_range(1, nodes - 1));
            offer(REQ_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
            random_items++;
        end

        quiesce();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ topological_sort_kahn_top.f @@
+incdir+hdl
hdl/tsk_pkg.sv
hdl/tsk_ram.sv
hdl/topological_sort_kahn_top.sv
hdl/tsk_checker.sv
bench/kahn_order_checker.sv
bench/testbench.sv
